### rtl/core/mbsp_pkg.sv
// Shared constants, message record and data-count lookup for the MIDI byte parser.
// Used by mbsp_core, midi_byte_stream_parser and mbsp_checker. No dependencies.
package mbsp_pkg;

  localparam logic [7:0] ST_CHANNEL_MIN = 8'h80;
  localparam logic [7:0] ST_SYSEX_START = 8'hF0;
  localparam logic [7:0] ST_MTC_QUARTER = 8'hF1;
  localparam logic [7:0] ST_SONG_POS    = 8'hF2;
  localparam logic [7:0] ST_SONG_SELECT = 8'hF3;
  localparam logic [7:0] ST_TUNE_REQ    = 8'hF6;
  localparam logic [7:0] ST_SYSEX_END   = 8'hF7;
  localparam logic [7:0] ST_REALTIME    = 8'hF8;
  localparam logic [3:0] KIND_PROGRAM   = 4'hC;
  localparam logic [3:0] KIND_PRESSURE  = 4'hD;
  localparam logic [3:0] KIND_SYSTEM    = 4'hF;

  localparam int unsigned MSG_W = 24;

  typedef struct packed {
    logic [1:0] msg_length;
    logic [6:0] msg_data_second;
    logic [6:0] msg_data_first;
    logic [7:0] msg_status;
  } msg_t;

  function automatic logic [1:0] data_needed(input logic [7:0] st);
    logic [1:0] n;
    n = 2'd0;
    if (st[7:4] != KIND_SYSTEM) begin
      if (st[7:4] == KIND_PROGRAM || st[7:4] == KIND_PRESSURE) begin
        n = 2'd1;
      end else if (st >= ST_CHANNEL_MIN) begin
        n = 2'd2;
      end
    end else if (st == ST_MTC_QUARTER || st == ST_SONG_SELECT) begin
      n = 2'd1;
    end else if (st == ST_SONG_POS) begin
      n = 2'd2;
    end
    return n;
  endfunction

endpackage

### rtl/core/midi_byte_stream_parser.sv
// MIDI byte-stream parser, top level: input register, parser core, result register.
// An accepted byte waits in the input register; its message, if any, goes to the result register.
// Throughput: one byte per cycle; a result held by m_tready low holds the input register.
// Reset (rst, synchronous) empties both registers, clears running status and returns
// the parser to waiting for a status byte. Depends on mbsp_pkg and mbsp_core.
module midi_byte_stream_parser
  import mbsp_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [7:0]       s_tdata,   // [7:0] data_byte
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [MSG_W-1:0] m_tdata    // [7:0] msg_status, [14:8] msg_data_first,
                                      // [21:15] msg_data_second, [23:22] msg_length
);

  logic       in_valid;
  logic [7:0] in_byte;
  logic       fire;
  logic       emit;
  msg_t       msg;
  msg_t       out_msg;

  assign fire     = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
    end
  end

  mbsp_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (fire),
    .data_byte (in_byte),
    .emit      (emit),
    .msg       (msg)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= emit;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      out_msg <= msg;
    end
  end

  assign m_tdata = out_msg;

endmodule

### rtl/core/mbsp_core.sv
// Parser state and per-byte next-state logic: running status, data collection, sysex.
// Depends on mbsp_pkg.
module mbsp_core
  import mbsp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] data_byte,
  output logic       emit,
  output msg_t       msg
);

  typedef enum logic [1:0] {
    MODE_WAIT    = 2'd0,
    MODE_COLLECT = 2'd1,
    MODE_SYSEX   = 2'd2
  } mode_t;

  mode_t      mode, mode_next;
  logic [7:0] running_status, running_status_next;
  logic [7:0] current_status, current_status_next;
  logic [1:0] collected_count, collected_count_next;
  logic [1:0] expected_count, expected_count_next;
  logic [6:0] data0, data0_next;
  logic [6:0] data1, data1_next;

  logic       take_en;
  logic [7:0] take_status;
  logic [1:0] take_exp;
  logic [1:0] take_cnt;
  logic [1:0] cnt_inc;
  logic [6:0] d0_new;
  logic [6:0] d1_new;

  always_comb begin
    mode_next            = mode;
    running_status_next  = running_status;
    current_status_next  = current_status;
    collected_count_next = collected_count;
    expected_count_next  = expected_count;
    emit                 = 1'b0;
    msg                  = '0;
    take_en              = 1'b0;
    take_status          = current_status;
    take_exp             = expected_count;
    take_cnt             = collected_count;

    if (data_byte >= ST_REALTIME) begin
      emit = 1'b1;
      msg  = '{msg_length: 2'd1, msg_data_second: 7'd0, msg_data_first: 7'd0,
               msg_status: data_byte};
    end else if (data_byte[7]) begin
      if (data_byte == ST_SYSEX_START) begin
        mode_next           = MODE_SYSEX;
        running_status_next = '0;
      end else if (data_byte == ST_SYSEX_END) begin
        mode_next            = MODE_WAIT;
        collected_count_next = '0;
        running_status_next  = '0;
      end else begin
        running_status_next  = (data_byte[7:4] == KIND_SYSTEM) ? 8'd0 : data_byte;
        current_status_next  = data_byte;
        collected_count_next = '0;
        expected_count_next  = data_needed(data_byte);
        if (data_needed(data_byte) == 2'd0) begin
          mode_next = MODE_WAIT;
          if (data_byte == ST_TUNE_REQ) begin
            emit = 1'b1;
            msg  = '{msg_length: 2'd1, msg_data_second: 7'd0, msg_data_first: 7'd0,
                     msg_status: data_byte};
          end
        end else begin
          mode_next = MODE_COLLECT;
        end
      end
    end else begin
      unique case (mode)
        MODE_COLLECT: take_en = 1'b1;
        MODE_SYSEX:   take_en = 1'b0;
        default: begin
          if (running_status != 8'd0) begin
            take_en     = 1'b1;
            take_status = running_status;
            take_exp    = data_needed(running_status);
            take_cnt    = 2'd0;
          end
        end
      endcase
    end

    cnt_inc = take_cnt + 2'd1;
    d0_new  = (take_cnt == 2'd0) ? data_byte[6:0] : data0;
    d1_new  = (take_cnt == 2'd1) ? data_byte[6:0] : data1;

    if (take_en) begin
      current_status_next = take_status;
      expected_count_next = take_exp;
      if (cnt_inc >= take_exp) begin
        emit = 1'b1;
        msg  = '{msg_length:      2'd1 + take_exp,
                 msg_data_second: (take_exp >= 2'd2) ? d1_new : 7'd0,
                 msg_data_first:  (take_exp >= 2'd1) ? d0_new : 7'd0,
                 msg_status:      take_status};
        mode_next            = MODE_WAIT;
        collected_count_next = '0;
      end else begin
        mode_next            = MODE_COLLECT;
        collected_count_next = cnt_inc;
      end
    end

    data0_next = (take_en && take_cnt == 2'd0) ? data_byte[6:0] : data0;
    data1_next = (take_en && take_cnt == 2'd1) ? data_byte[6:0] : data1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= MODE_WAIT;
      running_status  <= '0;
      current_status  <= '0;
      collected_count <= '0;
      expected_count  <= '0;
      data0           <= '0;
      data1           <= '0;
    end else if (step) begin
      mode            <= mode_next;
      running_status  <= running_status_next;
      current_status  <= current_status_next;
      collected_count <= collected_count_next;
      expected_count  <= expected_count_next;
      data0           <= data0_next;
      data1           <= data1_next;
    end
  end

endmodule

### rtl/core/mbsp_checker.sv
// Port-level checks for midi_byte_stream_parser, attached by bind.
// Depends on mbsp_pkg.
module mbsp_checker
  import mbsp_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [MSG_W-1:0] m_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result request changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result request after reset");

  a_msg_form: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[7] && m_tdata[23:22] != 2'd0)
    else $error("malformed status or length");

  a_single_byte: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[23:22] == 2'd1 |->
      m_tdata[21:8] == 14'd0 && (m_tdata[7:0] == ST_TUNE_REQ || m_tdata[7:0] >= ST_REALTIME))
    else $error("one-byte message is not real-time or tune request");

  a_two_byte: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[23:22] == 2'd2 |-> m_tdata[21:15] == 7'd0)
    else $error("second data byte set on two-byte message");

endmodule

bind midi_byte_stream_parser mbsp_checker u_mbsp_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
